### rtl/sca_pkg.sv
// sca_pkg: shared types, codes and sizes for the stack calculator
// no dependencies
package sca_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned DepthW = 7;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_SQRT = 3'd5,
    CMD_OUT  = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_NEGROOT = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [31:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic [2:0]         status;
    logic [6:0]         stack_depth;
  } out_beat_t;

  // request to the iterative unit: divide when is_div, else square root
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } iter_rsp_t;

endpackage

### rtl/sca_ram.sv
// sca_ram: generic single port write, single port read ram, registered read
// no dependencies
module sca_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sca_iter.sv
// sca_iter: shared one-bit-per-cycle unit for signed division and square root
// depends on sca_pkg
module sca_iter (
  input  logic              clk,
  input  logic              rst,
  input  sca_pkg::iter_req_t req,
  output sca_pkg::iter_rsp_t rsp
);
  import sca_pkg::*;

  logic        busy;
  logic        is_div;
  logic [4:0]  cnt;
  logic        neg_q;
  logic [31:0] quo;      // dividend shifting out, quotient shifting in
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [31:0] rad;      // sqrt radicand, two bits a step
  logic [31:0] root;

  logic [31:0] mag_a, mag_b;
  logic [32:0] rem_sh, rem_sub;
  logic [33:0] srem_sh, strial;
  logic [31:0] q_fix;

  assign mag_a = req.a[31] ? 32'(0 - req.a) : req.a;
  assign mag_b = req.b[31] ? 32'(0 - req.b) : req.b;

  // restoring divide step
  assign rem_sh  = {rem[31:0], quo[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // restoring square root step
  assign srem_sh = {rem[31:0], rad[31:30]};
  assign strial  = srem_sh - {root, 2'b01};

  assign q_fix = neg_q ? 32'(0 - {quo[30:0], ~rem_sub[32]})
                       : {quo[30:0], ~rem_sub[32]};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= req.is_div ? 5'd31 : 5'd15;
        neg_q  <= req.a[31] ^ req.b[31];
        quo    <= mag_a;
        dvs    <= mag_b;
        rad    <= req.a;
        rem    <= '0;
        root   <= '0;
      end else if (busy) begin
        if (is_div) begin
          quo <= {quo[30:0], ~rem_sub[32]};
          rem <= rem_sub[32] ? rem_sh : rem_sub;
          if (cnt == 5'd0) begin
            busy       <= 1'b0;
            rsp.done   <= 1'b1;
            rsp.result <= q_fix;
          end
        end else begin
          rad  <= {rad[29:0], 2'b00};
          rem  <= strial[33] ? srem_sh[32:0] : strial[32:0];
          root <= {root[30:0], ~strial[33]};
          if (cnt == 5'd0) begin
            busy       <= 1'b0;
            rsp.done   <= 1'b1;
            rsp.result <= {root[30:0], ~strial[33]};
          end
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

endmodule

### rtl/stack_calculator_alu_core.sv
// stack_calculator_alu_core: rpn stack calculator, stack held in one ram
// depends on sca_pkg, sca_ram, sca_iter
//
//  channel | signals                        | width | direction
//  in      | in_valid, in_ready, in_data    | 35    | to core
//  out     | out_valid, out_ready, out_data | 43    | from core
//
// push and underflow pass accept, decide and result; add, sub, mul, out, divide
// by zero and negative root pass top read, next read, execute and result.
// div and sqrt also pass start, 32 or 16 steps of the shared bit-serial unit,
// then done. one item at a time; a new beat is taken only once the result
// register is free. reset empties the stack at once (no clearing pass); out
// stalls hold the result register and block further input.
module stack_calculator_alu_core #(
  parameter int unsigned StackDepth = sca_pkg::DefStackDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sca_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sca_pkg::out_beat_t out_data
);
  import sca_pkg::*;

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_WAIT, S_RESP
  } state_t;

  state_t        state;
  logic [SpW-1:0] sp;
  cmd_t          cmd;
  logic [31:0]   opnd;
  logic [31:0]   a_val;
  logic          we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  iter_req_t     ireq;
  iter_rsp_t     irsp;
  logic [31:0]   prod;

  sca_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  sca_iter u_iter (.clk(clk), .rst(rst), .req(ireq), .rsp(irsp));

  assign in_ready = (state == S_IDLE);
  assign prod     = 32'(a_val * rdata);

  // read address follows the state
  always_comb begin
    raddr = AddrW'(sp - SpW'(1));
    if (state == S_RDB && cmd != CMD_SQRT && cmd != CMD_OUT) begin
      raddr = AddrW'(sp - SpW'(2));
    end
  end

  // sequencer, stack pointer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
      ireq.start <= 1'b0;
    end else begin
      we         <= 1'b0;
      ireq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd  <= cmd_t'(in_data.command);
            opnd <= in_data.operand_value;
            out_data <= '0;
            state <= S_RDA;
          end
        end
        S_RDA: begin
          // decide errors; top read issued this cycle
          state <= S_RESP;
          out_valid <= 1'b1;
          out_data.stack_depth <= 7'(sp);
          unique case (cmd)
            CMD_PUSH: begin
              if (sp == SpW'(StackDepth)) begin
                out_data.status <= ST_OVER;
              end else begin
                we    <= 1'b1;
                waddr <= AddrW'(sp);
                wdata <= opnd;
                sp    <= sp + SpW'(1);
                out_data.stack_depth <= 7'(sp + SpW'(1));
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (sp < SpW'(2)) begin
                out_data.status <= ST_UNDER;
              end else begin
                state     <= S_RDB;
                out_valid <= 1'b0;
              end
            end
            CMD_SQRT, CMD_OUT: begin
              if (sp == '0) begin
                out_data.status <= ST_UNDER;
              end else begin
                state     <= S_RDB;
                out_valid <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_RDB: begin
          // top arrives; for two-operand commands the next read (b) is in flight
          a_val <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state     <= S_RESP;
          out_valid <= 1'b1;
          unique case (cmd)
            CMD_OUT: begin
              sp <= sp - SpW'(1);
              out_data.stack_depth <= 7'(sp - SpW'(1));
              out_data.out_value   <= a_val;
              out_data.out_valid   <= 1'b1;
            end
            CMD_SQRT: begin
              if (a_val[31]) begin
                out_data.status <= ST_NEGROOT;
              end else begin
                ireq.start  <= 1'b1;
                ireq.is_div <= 1'b0;
                ireq.a      <= a_val;
                ireq.b      <= '0;
                state       <= S_WAIT;
                out_valid   <= 1'b0;
              end
            end
            CMD_DIV: begin
              if (rdata == '0) begin
                out_data.status <= ST_DIVZERO;
              end else begin
                ireq.start  <= 1'b1;
                ireq.is_div <= 1'b1;
                ireq.a      <= a_val;
                ireq.b      <= rdata;
                state       <= S_WAIT;
                out_valid   <= 1'b0;
              end
            end
            default: begin
              we    <= 1'b1;
              waddr <= AddrW'(sp - SpW'(2));
              wdata <= (cmd == CMD_ADD) ? a_val + rdata :
                       (cmd == CMD_SUB) ? a_val - rdata : prod;
              sp    <= sp - SpW'(1);
              out_data.stack_depth <= 7'(sp - SpW'(1));
            end
          endcase
        end
        S_WAIT: begin
          if (irsp.done) begin
            we        <= 1'b1;
            wdata     <= irsp.result;
            state     <= S_RESP;
            out_valid <= 1'b1;
            if (cmd == CMD_DIV) begin
              waddr <= AddrW'(sp - SpW'(2));
              sp    <= sp - SpW'(1);
              out_data.stack_depth <= 7'(sp - SpW'(1));
            end else begin
              waddr <= AddrW'(sp - SpW'(1));
            end
          end
        end
        S_RESP: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/stack_calculator_alu_core_test.sv
// stack_calculator_alu_core_test: self-checking bench for the rpn stack calculator
// depends on sca_pkg and stack_calculator_alu_core; predicts each result beat in line
module stack_calculator_alu_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sca_pkg::*;

  localparam int unsigned MaxCycles = 3000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // predictor state
  logic [31:0] calc_stack [DefStackDepth];
  int unsigned calc_depth = 0;
  out_beat_t   pending_results [$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned cycles = 0;
  int unsigned status_seen [5];
  bit          steady_flow = 1'b0;

  stack_calculator_alu_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor square root by restoring bit pairs
  function automatic logic [31:0] floor_root(logic [31:0] x);
    logic [31:0] root;
    logic [31:0] bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // signed divide truncating toward zero, wraps on min / -1
  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // apply one command to the predicted stack and return the expected beat
  function automatic out_beat_t calc_predict(in_beat_t beat);
    out_beat_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    r = '0;
    r.status = ST_OK;
    case (cmd_t'(beat.command))
      CMD_PUSH: begin
        if (calc_depth >= DefStackDepth) r.status = ST_OVER;
        else begin
          calc_stack[calc_depth] = beat.operand_value;
          calc_depth++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (calc_depth < 2) r.status = ST_UNDER;
        else begin
          a = calc_stack[calc_depth-1];
          b = calc_stack[calc_depth-2];
          v = 0;
          case (cmd_t'(beat.command))
            CMD_ADD: v = a + b;
            CMD_SUB: v = a - b;
            CMD_MUL: v = a * b;
            default: begin
              if (b == 0) r.status = ST_DIVZERO;
              else v = trunc_quotient(a, b);
            end
          endcase
          if (r.status == ST_OK) begin
            calc_depth--;
            calc_stack[calc_depth-1] = v;
          end
        end
      end
      CMD_SQRT: begin
        if (calc_depth < 1) r.status = ST_UNDER;
        else if (calc_stack[calc_depth-1][31]) r.status = ST_NEGROOT;
        else calc_stack[calc_depth-1] = floor_root(calc_stack[calc_depth-1]);
      end
      CMD_OUT: begin
        if (calc_depth < 1) r.status = ST_UNDER;
        else begin
          calc_depth--;
          r.out_value = calc_stack[calc_depth];
          r.out_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.stack_depth = calc_depth[6:0];
    return r;
  endfunction

  // send one beat, random idle before it unless flow is steady;
  // valid drops only when idling or draining
  task automatic send_beat(cmd_t cmd, logic [31:0] value);
    in_beat_t beat;
    beat.command = cmd;
    beat.operand_value = value;
    if (!steady_flow) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= beat;
    pending_results.push_back(calc_predict(beat));
    beats_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(20);
      5: return -$urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // receiver readiness
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady_flow || ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        exp_beat = pending_results.pop_front();
        beats_checked++;
        if (exp_beat.status < 5) status_seen[exp_beat.status]++;
        if (out_data.out_value !== exp_beat.out_value) begin
          $error("out_value expected %0d got %0d", exp_beat.out_value, out_data.out_value);
          errors++;
        end
        if (out_data.out_valid !== exp_beat.out_valid) begin
          $error("out_valid expected %0b got %0b", exp_beat.out_valid, out_data.out_valid);
          errors++;
        end
        if (out_data.status !== exp_beat.status) begin
          $error("status expected %0d got %0d", exp_beat.status, out_data.status);
          errors++;
        end
        if (out_data.stack_depth !== exp_beat.stack_depth) begin
          $error("stack_depth expected %0d got %0d", exp_beat.stack_depth,
                 out_data.stack_depth);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // underflow on empty, each op, extremes, wrap and error cases
  task automatic test_directed();
    send_beat(CMD_OUT, 0);
    send_beat(CMD_SQRT, 0);
    send_beat(CMD_ADD, 0);
    send_beat(CMD_PUSH, 32'h7fff_ffff);
    send_beat(CMD_MUL, 0);
    send_beat(CMD_PUSH, 32'h7fff_ffff);
    send_beat(CMD_ADD, 0);
    send_beat(CMD_SQRT, 0);
    send_beat(CMD_PUSH, 32'hffff_ffff);
    send_beat(CMD_PUSH, 32'h8000_0000);
    send_beat(CMD_DIV, 0);
    send_beat(CMD_SUB, 0);
    send_beat(CMD_PUSH, 0);
    send_beat(CMD_PUSH, 32'd7);
    send_beat(CMD_DIV, 0);
    send_beat(CMD_OUT, 0);
    send_beat(CMD_PUSH, -32'd7);
    send_beat(CMD_DIV, 0);
    send_beat(CMD_PUSH, 32'h7fff_ffff);
    send_beat(CMD_SQRT, 0);
    send_beat(CMD_MUL, 0);
    send_beat(CMD_NOP, 32'h5555_aaaa);
    send_beat(CMD_OUT, 0);
    send_beat(CMD_OUT, 0);
    wait_drained();
  endtask

  // fill to capacity, push past it, then pop back to empty
  task automatic test_full_stack();
    while (calc_depth < DefStackDepth) send_beat(CMD_PUSH, $urandom);
    send_beat(CMD_PUSH, 32'h1234_5678);
    send_beat(CMD_SQRT, 0);
    send_beat(CMD_DIV, 0);
    while (calc_depth > 0) send_beat(CMD_OUT, 0);
    send_beat(CMD_OUT, 0);
    wait_drained();
  endtask

  // random command mix biased to keep the stack populated
  task automatic test_random_mix(int unsigned count, bit steady);
    cmd_t cmd;
    steady_flow = steady;
    repeat (count) begin
      if (calc_depth < 2 && $urandom_range(3) != 0) cmd = CMD_PUSH;
      else if (calc_depth > 60 && $urandom_range(1)) cmd = CMD_OUT;
      else cmd = cmd_t'($urandom_range(7));
      send_beat(cmd, rand_value());
    end
    wait_drained();
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_stack();
    test_random_mix(1300, 1'b0);
    test_random_mix(250, 1'b1);
    repeat (50) @(posedge clk);
    $display("sent %0d beats, checked %0d: ok %0d underflow %0d overflow %0d",
             beats_sent, beats_checked, status_seen[0], status_seen[1], status_seen[2]);
    $display("divide by zero %0d, negative root %0d", status_seen[3], status_seen[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### sim.f
rtl/sca_pkg.sv
rtl/sca_ram.sv
rtl/sca_iter.sv
rtl/stack_calculator_alu_core.sv
tb/stack_calculator_alu_core_test.sv
